// ----- hdl/rvmt_pkg.sv -----
// rvmt_pkg: shared types and constants for the row-vector matrix transform
package rvmt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int EL_W      = 32;
    localparam int N         = 4;
    localparam int ROW_W     = $clog2(N);
    localparam int PROD_W    = 2 * EL_W;
    localparam int ACC_W     = PROD_W + ROW_W;

    typedef logic signed [EL_W-1:0] t_elem;

    localparam t_elem EL_MAX = {1'b0, {(EL_W-1){1'b1}}};
    localparam t_elem EL_MIN = {1'b1, {(EL_W-1){1'b0}}};

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_XFORM = 1'b1
    } t_func;

    typedef logic [N-1:0][EL_W-1:0]   t_vec;
    typedef logic [N-1:0][ACC_W-1:0]  t_acc_vec;
    typedef logic [N-1:0][PROD_W-1:0] t_prod_vec;

    typedef struct packed {
        t_func             func;
        logic [ROW_W-1:0]  row_select;
        t_elem             in_x;
        t_elem             in_y;
        t_elem             in_z;
        t_elem             in_w;
    } t_in_item;

    typedef struct packed {
        t_elem out_x;
        t_elem out_y;
        t_elem out_z;
        t_elem out_w;
        logic  clipped;
    } t_out_item;

    // what travels from cell to cell besides the partial sums
    typedef struct packed {
        t_func            func;
        logic [ROW_W-1:0] row;
        t_vec             vec;
    } t_stage;

endpackage

// ----- hdl/rvmt_cell.sv -----
// rvmt_cell: one matrix row, its four multipliers and the running column sums
module rvmt_cell import rvmt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [ROW_W-1:0] i_cell_idx,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_stage           i_stage,
    input  t_acc_vec         i_acc,
    input  t_prod_vec        i_prod,
    output logic             o_valid,
    input  logic             i_ready,
    output t_stage           o_stage,
    output t_acc_vec         o_acc,
    output t_prod_vec        o_prod
);

    t_vec      r_mrow;
    logic      r_valid;
    t_stage    r_stage;
    t_acc_vec  r_acc;
    t_prod_vec r_prod;
    t_acc_vec  n_acc;
    t_prod_vec n_prod;
    logic      w_take;
    logic      w_load;
    t_elem     w_vk;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;
    assign w_load  = w_take && (i_stage.func == FUNC_LOAD) && (i_stage.row == i_cell_idx);
    assign w_vk    = i_stage.vec[i_cell_idx];

    // add the previous cell's products, form this row's products
    always_comb begin
        for (int j = 0; j < N; j++) begin
            n_acc[j]  = ACC_W'($signed(i_acc[j]) + ACC_W'($signed(i_prod[j])));
            n_prod[j] = PROD_W'($signed(PROD_W'(w_vk)) * $signed(PROD_W'($signed(r_mrow[j]))));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mrow  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_load) begin
                r_mrow <= i_stage.vec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_stage <= i_stage;
            r_acc   <= n_acc;
            r_prod  <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;
    assign o_acc   = r_acc;
    assign o_prod  = r_prod;

endmodule

// ----- hdl/rvmt_sat.sv -----
// rvmt_sat: final sum, fraction shift, saturation and the output register
module rvmt_sat import rvmt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_func     i_func,
    input  t_acc_vec  i_acc,
    input  t_prod_vec i_prod,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic                    r_valid;
    t_out_item               r_item;
    t_out_item               n_item;
    logic signed [ACC_W-1:0] w_sum [N];
    logic signed [ACC_W-1:0] w_sh  [N];
    logic [N-1:0]            w_clip;
    t_elem                   w_res [N];
    logic                    w_take;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        for (int j = 0; j < N; j++) begin
            w_sum[j]  = $signed(i_acc[j]) + ACC_W'($signed(i_prod[j]));
            w_sh[j]   = w_sum[j] >>> FRAC_BITS;
            // fits when all bits above the element's sign bit copy it
            w_clip[j] = !((&w_sh[j][ACC_W-1:EL_W-1]) || !(|w_sh[j][ACC_W-1:EL_W-1]));
            if (!w_clip[j]) begin
                w_res[j] = w_sh[j][EL_W-1:0];
            end else if (w_sh[j][ACC_W-1]) begin
                w_res[j] = EL_MIN;
            end else begin
                w_res[j] = EL_MAX;
            end
        end
        n_item.out_x   = w_res[0];
        n_item.out_y   = w_res[1];
        n_item.out_z   = w_res[2];
        n_item.out_w   = w_res[3];
        n_item.clipped = |w_clip;
    end

    // load transactions end here without a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && (i_func == FUNC_XFORM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- hdl/row_vector_matrix_transform.sv -----
// Row-vector times 4x4 matrix in signed Q16.16: one transaction per clock while
// the output is not stalled. The matrix is spread over a chain of four
// cells, one row each; a transaction walks the chain, each cell multiplying its
// vector element by its row with four 32x32 multipliers while the column sums
// move along, then a last stage adds, shifts and saturates into the output
// register. A load transaction travels the same chain and writes its row when
// it reaches that row's cell, so loads and transforms keep their order without
// draining. Each stage has its own valid bit, so gaps in the chain close up
// while a result waits. The matrix is all zeros after reset.
module row_vector_matrix_transform import rvmt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      w_valid [N+1];
    logic      w_ready [N+1];
    t_stage    w_stage [N+1];
    t_acc_vec  w_acc   [N+1];
    t_prod_vec w_prod  [N+1];

    assign w_valid[0]      = i_in_valid;
    assign o_in_ready      = w_ready[0];
    assign w_stage[0].func = i_in_item.func;
    assign w_stage[0].row  = i_in_item.row_select;
    assign w_stage[0].vec  = {i_in_item.in_w, i_in_item.in_z, i_in_item.in_y, i_in_item.in_x};
    assign w_acc[0]        = '0;
    assign w_prod[0]       = '0;

    for (genvar k = 0; k < N; k++) begin : g_cell
        rvmt_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (ROW_W'(k)),
            .i_valid    (w_valid[k]),
            .o_ready    (w_ready[k]),
            .i_stage    (w_stage[k]),
            .i_acc      (w_acc[k]),
            .i_prod     (w_prod[k]),
            .o_valid    (w_valid[k+1]),
            .i_ready    (w_ready[k+1]),
            .o_stage    (w_stage[k+1]),
            .o_acc      (w_acc[k+1]),
            .o_prod     (w_prod[k+1])
        );
    end

    rvmt_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[N]),
        .o_ready (w_ready[N]),
        .i_func  (w_stage[N].func),
        .i_acc   (w_acc[N]),
        .i_prod  (w_prod[N]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

// ----- hdl/rvmt_chk.sv -----
// rvmt_chk: port-level checks for the row-vector matrix transform
module rvmt_chk import rvmt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // with the output free to move, the whole chain moves
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled while output side was free");

    // a clipped result carries a limit value in some column
    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.clipped |->
            (o_out_item.out_x == EL_MAX || o_out_item.out_x == EL_MIN ||
             o_out_item.out_y == EL_MAX || o_out_item.out_y == EL_MIN ||
             o_out_item.out_z == EL_MAX || o_out_item.out_z == EL_MIN ||
             o_out_item.out_w == EL_MAX || o_out_item.out_w == EL_MIN))
        else $error("clipped set without a saturated column");

endmodule

bind row_vector_matrix_transform rvmt_chk u_rvmt_chk (.*);

// ----- dv/testbench.sv -----
// testbench: self-checking random and directed bench for the row-vector matrix transform
module testbench;
    import rvmt_pkg::*;

    localparam int    HOLD_CYCLES = 300;
    localparam int    STALL_LIMIT = 2000;
    localparam int    TAIL_CYCLES = 20;
    localparam int    PHASE_ITEMS = 320;
    localparam int    MAX_REPORTS = 10;
    localparam t_elem Q_ONE       = 32'sh0001_0000;
    localparam t_elem Q_NEG_ONE   = -32'sh0001_0000;
    localparam t_elem ALL_ONES    = -32'sd1;

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item result;
    } t_dir_row;

    typedef struct packed {
        logic      typed;
        t_out_item result;
    } t_typed_product;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    t_elem          matrix_copy [N][N] = '{default: '0};
    t_out_item      pending_products [$];
    t_typed_product typed_products [$];

    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_cnt      = 0;
    int stall_cycles  = 0;
    int mismatches    = 0;
    int n_loads       = 0;
    int n_xforms      = 0;
    int n_checked     = 0;
    int n_clipped     = 0;

    row_vector_matrix_transform u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // v * M with exact sums, floor shift and saturation
    function automatic t_out_item transform_row(input t_in_item it);
        t_elem              vec [N];
        t_elem              res [N];
        logic signed [63:0] prod;
        logic signed [65:0] acc;
        t_out_item          r;
        vec = '{it.in_x, it.in_y, it.in_z, it.in_w};
        r   = '0;
        for (int j = 0; j < N; j++) begin
            acc = '0;
            for (int k = 0; k < N; k++) begin
                prod = 64'(vec[k]) * 64'(matrix_copy[k][j]);
                acc  = acc + 66'(prod);
            end
            acc = acc >>> FRAC_BITS;
            if (acc > 66'(EL_MAX)) begin
                res[j]    = EL_MAX;
                r.clipped = 1'b1;
            end else if (acc < 66'(EL_MIN)) begin
                res[j]    = EL_MIN;
                r.clipped = 1'b1;
            end else begin
                res[j] = acc[EL_W-1:0];
            end
        end
        r.out_x = res[0];
        r.out_y = res[1];
        r.out_z = res[2];
        r.out_w = res[3];
        return r;
    endfunction

    function automatic t_in_item mk_item(input t_func f, input logic [ROW_W-1:0] rs,
                                         input t_elem x, y, z, w);
        t_in_item it;
        it.func       = f;
        it.row_select = rs;
        it.in_x       = x;
        it.in_y       = y;
        it.in_z       = z;
        it.in_w       = w;
        return it;
    endfunction

    function automatic t_out_item mk_result(input t_elem x, y, z, w, input logic clip);
        t_out_item r;
        r.out_x   = x;
        r.out_y   = y;
        r.out_z   = z;
        r.out_w   = w;
        r.clipped = clip;
        return r;
    endfunction

    function automatic t_dir_row drow(input t_func f, input logic [ROW_W-1:0] rs,
                                      input t_elem x, y, z, w,
                                      input logic typed = 1'b0, input t_out_item res = '0);
        t_dir_row d;
        d.item   = mk_item(f, rs, x, y, z, w);
        d.typed  = typed;
        d.result = res;
        return d;
    endfunction

    // mostly small values so that sums stay in range, some full-range and extremes
    function automatic t_elem rand_elem();
        t_elem picks [6];
        picks = '{EL_MAX, EL_MIN, '0, ALL_ONES, Q_ONE, Q_NEG_ONE};
        case ($urandom_range(0, 9))
            0, 1, 2: return t_elem'($urandom);
            3:       return picks[$urandom_range(0, 5)];
            default: return t_elem'(int'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000);
        endcase
    endfunction

    task automatic send_item(input t_in_item it, input logic typed, input t_out_item res);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        typed_products.push_back({typed, res});
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // matrix products (mostly a new B first, then rows of A) with some stray transactions mixed in
    task automatic random_phase(input int n_items);
        int       sent;
        int       first_row;
        t_in_item it;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                first_row = $urandom_range(0, N - 1);
                if ($urandom_range(0, 4) != 0) begin
                    for (int r = 0; r < N; r++) begin
                        it = mk_item(FUNC_LOAD, ROW_W'((first_row + r) % N),
                                     rand_elem(), rand_elem(), rand_elem(), rand_elem());
                        send_item(it, 1'b0, '0);
                        sent++;
                    end
                end
                repeat ($urandom_range(1, N)) begin
                    it = mk_item(FUNC_XFORM, ROW_W'($urandom),
                                 rand_elem(), rand_elem(), rand_elem(), rand_elem());
                    send_item(it, 1'b0, '0);
                    sent++;
                end
            end else begin
                it = mk_item(t_func'($urandom_range(0, 1)), ROW_W'($urandom),
                             t_elem'($urandom), t_elem'($urandom),
                             t_elem'($urandom), t_elem'($urandom));
                send_item(it, 1'b0, '0);
                sent++;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [EL_W-1:0] want, got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    // input side: update the matrix copy or queue the expected product
    always @(posedge i_clk) begin
        t_typed_product tp;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            tp = typed_products.pop_front();
            if (i_in_item.func == FUNC_LOAD) begin
                matrix_copy[i_in_item.row_select] =
                    '{i_in_item.in_x, i_in_item.in_y, i_in_item.in_z, i_in_item.in_w};
                n_loads++;
            end else begin
                pending_products.push_back(tp.typed ? tp.result : transform_row(i_in_item));
                n_xforms++;
            end
        end
    end

    // output side: compare against the oldest expected product
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_products.size() == 0) begin
                report_mismatch("result with none pending", 'x, o_out_item.out_x);
            end else begin
                want = pending_products.pop_front();
                n_checked++;
                if (want.clipped) n_clipped++;
                if (o_out_item.out_x !== want.out_x)
                    report_mismatch("out_x", want.out_x, o_out_item.out_x);
                if (o_out_item.out_y !== want.out_y)
                    report_mismatch("out_y", want.out_y, o_out_item.out_y);
                if (o_out_item.out_z !== want.out_z)
                    report_mismatch("out_z", want.out_z, o_out_item.out_z);
                if (o_out_item.out_w !== want.out_w)
                    report_mismatch("out_w", want.out_w, o_out_item.out_w);
                if (o_out_item.clipped !== want.clipped)
                    report_mismatch("clipped", EL_W'(want.clipped), EL_W'(o_out_item.clipped));
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (holds_done != hold_requests) begin
            i_out_ready <= 1'b0;
            if (hold_cnt == HOLD_CYCLES - 1) begin
                hold_cnt   <= 0;
                holds_done <= holds_done + 1;
            end else begin
                hold_cnt <= hold_cnt + 1;
            end
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("no transaction for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_dir_row dir_tab [22];
        dir_tab = '{
            // matrix is all zeros after reset
            drow(FUNC_XFORM, 2'd0, EL_MAX, EL_MIN, ALL_ONES, 32'sd1,
                 1'b1, mk_result('0, '0, '0, '0, 1'b0)),
            drow(FUNC_LOAD, 2'd0, Q_ONE, '0, '0, '0),
            drow(FUNC_LOAD, 2'd1, '0, Q_ONE, '0, '0),
            drow(FUNC_LOAD, 2'd2, '0, '0, Q_ONE, '0),
            drow(FUNC_LOAD, 2'd3, '0, '0, '0, Q_ONE),
            // identity passes the vector through; row select ignored on transform
            drow(FUNC_XFORM, 2'd3, EL_MAX, EL_MIN, ALL_ONES, 32'sh1234_5678,
                 1'b1, mk_result(EL_MAX, EL_MIN, ALL_ONES, 32'sh1234_5678, 1'b0)),
            drow(FUNC_XFORM, 2'd1, Q_ONE, Q_NEG_ONE, 32'sh7FFF_0000, EL_MIN,
                 1'b1, mk_result(Q_ONE, Q_NEG_ONE, 32'sh7FFF_0000, EL_MIN, 1'b0)),
            drow(FUNC_LOAD, 2'd0, EL_MAX, EL_MIN, Q_ONE, '0),
            // saturation both ways, most negative value as an operand
            drow(FUNC_XFORM, 2'd0, EL_MAX, '0, '0, '0,
                 1'b1, mk_result(EL_MAX, EL_MIN, EL_MAX, '0, 1'b1)),
            drow(FUNC_XFORM, 2'd0, EL_MIN, '0, '0, '0,
                 1'b1, mk_result(EL_MIN, EL_MAX, EL_MIN, '0, 1'b1)),
            // shift rounds toward minus infinity
            drow(FUNC_XFORM, 2'd2, ALL_ONES, '0, '0, '0),
            drow(FUNC_LOAD, 2'd1, EL_MIN, EL_MIN, EL_MIN, EL_MIN),
            drow(FUNC_LOAD, 2'd2, EL_MAX, EL_MAX, EL_MAX, EL_MAX),
            drow(FUNC_LOAD, 2'd3, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES),
            drow(FUNC_XFORM, 2'd0, 32'sd1, 32'sd1, 32'sd1, 32'sd1),
            drow(FUNC_XFORM, 2'd1, EL_MAX, EL_MAX, EL_MAX, EL_MAX),
            drow(FUNC_XFORM, 2'd2, EL_MIN, EL_MIN, EL_MIN, EL_MIN),
            drow(FUNC_XFORM, 2'd3, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES),
            drow(FUNC_XFORM, 2'd0, '0, '0, '0, '0,
                 1'b1, mk_result('0, '0, '0, '0, 1'b0)),
            drow(FUNC_XFORM, 2'd0, '0, Q_ONE, Q_NEG_ONE, '0),
            // zero row wipes its contribution
            drow(FUNC_LOAD, 2'd2, '0, '0, '0, '0),
            drow(FUNC_XFORM, 2'd1, '0, '0, Q_ONE, '0,
                 1'b1, mk_result('0, '0, '0, '0, 1'b0))
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].result);

        // long receiver hold-off while the sender keeps offering
        hold_requests++;
        random_phase(PHASE_ITEMS);
        idle_pct  = 51;
        random_phase(PHASE_ITEMS);
        idle_pct  = 0;
        stall_pct = 51;
        random_phase(PHASE_ITEMS);
        idle_pct  = 23;
        stall_pct = 23;
        random_phase(PHASE_ITEMS);

        i_in_valid <= 1'b0;
        stall_pct = 0;
        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d row loads and %0d transforms sent, %0d results checked (%0d saturated)",
                 n_loads, n_xforms, n_checked, n_clipped);
        $display("idling phases: none, sender, receiver, both; one long output hold-off");
        if (mismatches == 0 && pending_products.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/rvmt_pkg.sv
hdl/rvmt_cell.sv
hdl/rvmt_sat.sv
hdl/row_vector_matrix_transform.sv
hdl/rvmt_chk.sv
dv/testbench.sv
